// File: src/qrs_pkg.sv
package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int TOL_BITS  = 16;

  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

endpackage

// File: src/qrs_if.sv
interface qrs_coef_if #(
  parameter int WORD_BITS = qrs_pkg::WORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] coef_a;
  logic signed [WORD_BITS-1:0] coef_b;
  logic signed [WORD_BITS-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_result_if #(
  parameter int WORD_BITS = qrs_pkg::WORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  root_count;
  logic signed [WORD_BITS-1:0] root_first;
  logic signed [WORD_BITS-1:0] root_second;
  logic                        overflow;

  modport source (output valid, root_count, root_first, root_second, overflow, input ready);
  modport sink   (input valid, root_count, root_first, root_second, overflow, output ready);
endinterface

interface qrs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [qrs_pkg::TOL_BITS-1:0]  zero_tolerance;

  modport source (output valid, zero_tolerance, input ready);
  modport sink   (input valid, zero_tolerance, output ready);
endinterface

// File: src/qrs_isqrt.sv
module qrs_isqrt #(
  parameter int RAD_BITS  = 66,
  parameter int SIDE_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [RAD_BITS-1:0]           in_rad,
  input  logic [SIDE_BITS-1:0]          in_side,
  output logic                          out_valid,
  output logic [RAD_BITS/2-1:0]         out_root,
  output logic [SIDE_BITS-1:0]          out_side
);

  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int REM_BITS  = ROOT_BITS + 2;

  logic                 vld  [ROOT_BITS+1];
  logic [RAD_BITS-1:0]  rad  [ROOT_BITS+1];
  logic [REM_BITS-1:0]  rem  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] root [ROOT_BITS+1];
  logic [SIDE_BITS-1:0] side [ROOT_BITS+1];

  assign vld[0]  = in_valid;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    logic [REM_BITS-1:0] rem_sh;
    logic [REM_BITS-1:0] trial;
    logic                take;

    always_comb begin
      rem_sh = {rem[k][REM_BITS-3:0], rad[k][RAD_BITS-1 -: 2]};
      trial  = {root[k], 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1]  <= {rad[k][RAD_BITS-3:0], 2'b00};
        rem[k+1]  <= take ? rem_sh - trial : rem_sh;
        root[k+1] <= {root[k][ROOT_BITS-2:0], take};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[ROOT_BITS];
  assign out_root  = root[ROOT_BITS];
  assign out_side  = side[ROOT_BITS];

endmodule

// File: src/qrs_div.sv
module qrs_div #(
  parameter int NUM_BITS  = 50,
  parameter int DEN_BITS  = 33,
  parameter int SIDE_BITS = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [NUM_BITS-1:0]  in_num1,
  input  logic [NUM_BITS-1:0]  in_num2,
  input  logic [DEN_BITS-1:0]  in_den,
  input  logic [SIDE_BITS-1:0] in_side,
  output logic                 out_valid,
  output logic [NUM_BITS-1:0]  out_quo1,
  output logic [NUM_BITS-1:0]  out_quo2,
  output logic [SIDE_BITS-1:0] out_side
);

  logic                 vld  [NUM_BITS+1];
  logic [NUM_BITS-1:0]  num1 [NUM_BITS+1];
  logic [NUM_BITS-1:0]  num2 [NUM_BITS+1];
  logic [DEN_BITS-1:0]  rem1 [NUM_BITS+1];
  logic [DEN_BITS-1:0]  rem2 [NUM_BITS+1];
  logic [DEN_BITS-1:0]  den  [NUM_BITS+1];
  logic [SIDE_BITS-1:0] side [NUM_BITS+1];

  assign vld[0]  = in_valid;
  assign num1[0] = in_num1;
  assign num2[0] = in_num2;
  assign rem1[0] = '0;
  assign rem2[0] = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
    logic [DEN_BITS:0] r1, r2, dx;
    logic              ge1, ge2;
    logic [DEN_BITS:0] d1, d2;

    always_comb begin
      dx  = {1'b0, den[k]};
      r1  = {rem1[k], num1[k][NUM_BITS-1]};
      r2  = {rem2[k], num2[k][NUM_BITS-1]};
      ge1 = r1 >= dx;
      ge2 = r2 >= dx;
      d1  = ge1 ? r1 - dx : r1;
      d2  = ge2 ? r2 - dx : r2;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num1[k+1] <= {num1[k][NUM_BITS-2:0], ge1};
        num2[k+1] <= {num2[k][NUM_BITS-2:0], ge2};
        rem1[k+1] <= d1[DEN_BITS-1:0];
        rem2[k+1] <= d2[DEN_BITS-1:0];
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[NUM_BITS];
  assign out_quo1  = num1[NUM_BITS];
  assign out_quo2  = num2[NUM_BITS];
  assign out_side  = side[NUM_BITS];

endmodule

// File: src/quadratic_root_solver_core.sv
// channel  | dir | beat
// ---------+-----+--------------------------------------------------
// coef     | in  | coef_a, coef_b, coef_c (signed fixed point)
// result   | out | root_count, root_first, root_second, overflow
// cfg      | in  | zero_tolerance, always ready
//
// One beat enters per cycle while no result waits unaccepted. The pipeline
// runs through square root stages (one root bit each) and then divider stages
// (one quotient bit each). The whole pipeline holds while a result waits
// unaccepted. Reset clears all valid bits and loads zero_tolerance with 1.
module quadratic_root_solver_core #(
  parameter int WORD_BITS = qrs_pkg::WORD_BITS,
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
  input logic           clk,
  input logic           rst,
  qrs_coef_if.sink      coef,
  qrs_result_if.source  result,
  qrs_cfg_if.sink       cfg
);

  localparam int W   = WORD_BITS;
  localparam int DW  = 2 * W + 2;
  localparam int SQ  = DW / 2;
  localparam int MW  = W + 2;
  localparam int NW  = MW + FRAC_BITS;
  localparam int DNW = W + 1;

  typedef struct packed {
    logic [1:0]     count;
    logic           use1;
    logic           use2;
    logic           two;
    logic           pre_neg;
    logic [W-1:0]   pre_mag;
    logic [DNW-1:0] den;
    logic           den_neg;
    logic           nb;
    logic [W-1:0]   mb;
  } sq_side_t;

  typedef struct packed {
    logic [1:0] count;
    logic       use1;
    logic       use2;
    logic       neg1;
    logic       neg2;
  } dv_side_t;

  logic [qrs_pkg::TOL_BITS-1:0] tol;
  logic en;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= qrs_pkg::TOL_RESET;
    end else if (cfg.valid) begin
      tol <= cfg.zero_tolerance;
    end
  end

  assign en         = !result.valid || result.ready;
  assign coef.ready = en;

  // decode
  logic         v0, na0, nb0, nc0, za0, zb0, zc0;
  logic [W-1:0] ma0, mb0, mc0;
  logic [W-1:0] ma_c, mb_c, mc_c, tol_w;

  always_comb begin
    tol_w = W'(tol);
    ma_c  = coef.coef_a[W-1] ? W'(-coef.coef_a) : W'(coef.coef_a);
    mb_c  = coef.coef_b[W-1] ? W'(-coef.coef_b) : W'(coef.coef_b);
    mc_c  = coef.coef_c[W-1] ? W'(-coef.coef_c) : W'(coef.coef_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= coef.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na0 <= coef.coef_a[W-1];
      nb0 <= coef.coef_b[W-1];
      nc0 <= coef.coef_c[W-1];
      ma0 <= ma_c;
      mb0 <= mb_c;
      mc0 <= mc_c;
      za0 <= ma_c <= tol_w;
      zb0 <= mb_c <= tol_w;
      zc0 <= mc_c <= tol_w;
    end
  end

  // products
  logic           v1, na1, nb1, nc1, za1, zb1, zc1;
  logic [W-1:0]   ma1, mb1, mc1;
  logic [2*W-1:0] b2, ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2  <= (2*W)'(mb0) * (2*W)'(mb0);
      ac  <= (2*W)'(ma0) * (2*W)'(mc0);
      na1 <= na0;
      nb1 <= nb0;
      nc1 <= nc0;
      ma1 <= ma0;
      mb1 <= mb0;
      mc1 <= mc0;
      za1 <= za0;
      zb1 <= zb0;
      zc1 <= zc0;
    end
  end

  // discriminant and case selection
  logic [DW-1:0] b2e, p4, tt, dm_c;
  logic          dneg_c, gt_c;
  sq_side_t      sd_c;

  always_comb begin
    b2e = DW'(b2);
    p4  = DW'(ac) << 2;
    tt  = DW'(tol) << FRAC_BITS;
    if (na1 != nc1) begin
      dneg_c = 1'b0;
      dm_c   = b2e + p4;
    end else if (b2e >= p4) begin
      dneg_c = 1'b0;
      dm_c   = b2e - p4;
    end else begin
      dneg_c = 1'b1;
      dm_c   = p4 - b2e;
    end
    gt_c       = dm_c > tt;
    sd_c.nb    = nb1;
    sd_c.mb    = mb1;
    sd_c.two   = !za1 && !dneg_c && gt_c;
    sd_c.use2  = sd_c.two;
    if (za1) begin
      priority if (zb1 && zc1) begin
        sd_c.count = qrs_pkg::CNT_INF;
      end else if (zb1) begin
        sd_c.count = qrs_pkg::CNT_NONE;
      end else begin
        sd_c.count = qrs_pkg::CNT_ONE;
      end
      sd_c.use1    = !zb1 && !zc1;
      sd_c.pre_mag = mc1;
      sd_c.pre_neg = !nc1;
      sd_c.den     = DNW'(mb1);
      sd_c.den_neg = nb1;
    end else begin
      priority if (sd_c.two) begin
        sd_c.count = qrs_pkg::CNT_TWO;
      end else if (!gt_c) begin
        sd_c.count = qrs_pkg::CNT_ONE;
      end else begin
        sd_c.count = qrs_pkg::CNT_NONE;
      end
      sd_c.use1    = sd_c.two || !gt_c;
      sd_c.pre_mag = mb1;
      sd_c.pre_neg = !nb1;
      sd_c.den     = {ma1, 1'b0};
      sd_c.den_neg = na1;
    end
  end

  logic          v2;
  logic [DW-1:0] dm2;
  sq_side_t      sd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm2 <= dm_c;
      sd2 <= sd_c;
    end
  end

  logic          sq_valid;
  logic [SQ-1:0] sq_root;
  sq_side_t      sq_side;

  qrs_isqrt #(
    .RAD_BITS  (DW),
    .SIDE_BITS ($bits(sq_side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .in_rad    (dm2),
    .in_side   (sd2),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // numerators
  logic signed [MW:0] nbv, sv, v1s, v2s;
  logic [MW-1:0]      mag1_c, mag2_c;
  logic               neg1_c, neg2_c;
  dv_side_t           dd_c;

  always_comb begin
    nbv = sq_side.nb ? $signed({3'b000, sq_side.mb}) : -$signed({3'b000, sq_side.mb});
    sv  = $signed({2'b00, sq_root});
    v1s = nbv + sv;
    v2s = nbv - sv;
    if (sq_side.two) begin
      neg1_c = v1s[MW];
      neg2_c = v2s[MW];
      mag1_c = v1s[MW] ? MW'(-v1s) : MW'(v1s);
      mag2_c = v2s[MW] ? MW'(-v2s) : MW'(v2s);
    end else begin
      neg1_c = sq_side.pre_neg;
      neg2_c = 1'b0;
      mag1_c = MW'(sq_side.pre_mag);
      mag2_c = '0;
    end
    dd_c.count = sq_side.count;
    dd_c.use1  = sq_side.use1;
    dd_c.use2  = sq_side.use2;
    dd_c.neg1  = neg1_c ^ sq_side.den_neg;
    dd_c.neg2  = neg2_c ^ sq_side.den_neg;
  end

  logic           v3;
  logic [NW-1:0]  num1_3, num2_3;
  logic [DNW-1:0] den3;
  dv_side_t       dd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1_3 <= {mag1_c, {FRAC_BITS{1'b0}}};
      num2_3 <= {mag2_c, {FRAC_BITS{1'b0}}};
      den3   <= sq_side.den;
      dd3    <= dd_c;
    end
  end

  logic          dv_valid;
  logic [NW-1:0] quo1, quo2;
  dv_side_t      dv_side;

  qrs_div #(
    .NUM_BITS  (NW),
    .DEN_BITS  (DNW),
    .SIDE_BITS ($bits(dv_side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_num1   (num1_3),
    .in_num2   (num2_3),
    .in_den    (den3),
    .in_side   (dd3),
    .out_valid (dv_valid),
    .out_quo1  (quo1),
    .out_quo2  (quo2),
    .out_side  (dv_side)
  );

  // saturate
  logic [NW-1:0] lim1, lim2;
  logic          ovf1, ovf2;
  logic [W-1:0]  w1, w2, r1_c, r2_c;

  always_comb begin
    lim1 = dv_side.neg1 ? NW'(1) << (W - 1) : (NW'(1) << (W - 1)) - NW'(1);
    lim2 = dv_side.neg2 ? NW'(1) << (W - 1) : (NW'(1) << (W - 1)) - NW'(1);
    ovf1 = quo1 > lim1;
    ovf2 = quo2 > lim2;
    w1   = ovf1 ? lim1[W-1:0] : quo1[W-1:0];
    w2   = ovf2 ? lim2[W-1:0] : quo2[W-1:0];
    r1_c = dv_side.use1 ? (dv_side.neg1 ? -w1 : w1) : '0;
    r2_c = dv_side.use2 ? (dv_side.neg2 ? -w2 : w2) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.root_count  <= dv_side.count;
      result.root_first  <= r1_c;
      result.root_second <= r2_c;
      result.overflow    <= (dv_side.use1 && ovf1) || (dv_side.use2 && ovf2);
    end
  end

  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.root_count == qrs_pkg::CNT_NONE ||
                     result.root_count == qrs_pkg::CNT_INF)
    |-> result.root_first == '0 && result.root_second == '0 && !result.overflow)
    else $error("root fields set without a root");

  a_second_unused: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.root_count != qrs_pkg::CNT_TWO |-> result.root_second == '0)
    else $error("second root set without two roots");

  a_ovf_at_limit: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.overflow
    |-> result.root_first == {1'b0, {(W-1){1'b1}}} ||
        result.root_first == {1'b1, {(W-1){1'b0}}} ||
        result.root_second == {1'b0, {(W-1){1'b1}}} ||
        result.root_second == {1'b1, {(W-1){1'b0}}})
    else $error("overflow without a saturated root");

endmodule
